### rtl/core/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// shared types and constants of the q24.8 fixed-point alu pipeline
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int DATA_W     = 32;
    localparam int RADIX_BITS = 4;
    localparam int NUM_W      = DATA_W + FRAC_BITS;
    localparam int DIV_STAGES = (NUM_W + RADIX_BITS - 1) / RADIX_BITS;
    localparam int QUO_W      = DIV_STAGES * RADIX_BITS;
    localparam int PROD_W     = 2 * DATA_W;

    localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [3:0] {
        K_ADD      = 4'd0,
        K_SUB      = 4'd1,
        K_MUL      = 4'd2,
        K_DIV      = 4'd3,
        K_CMP      = 4'd4,
        K_MIN      = 4'd5,
        K_MAX      = 4'd6,
        K_INC      = 4'd7,
        K_DEC      = 4'd8,
        K_TO_INT   = 4'd9,
        K_FROM_INT = 4'd10
    } t_kind;

    typedef enum logic [1:0] {
        SEL_SIMPLE,
        SEL_MUL,
        SEL_DIV
    } t_sel;

    typedef struct packed {
        logic [3:0]               kind;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } t_fpa_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     less_flag;
        logic                     equal_flag;
        logic                     greater_flag;
        logic                     overflow_flag;
        logic                     divide_error;
    } t_fpa_out;

    typedef struct packed {
        t_sel                sel;
        logic                neg;
        t_fpa_out            simple;
        logic [PROD_W-1:0]   prod;
        logic [DATA_W-1:0]   dvs;
        logic [DATA_W:0]     rem;
        logic [QUO_W-1:0]    quo;
    } t_fpa_pipe;

endpackage

### rtl/core/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// operand decode, simple operations, magnitude product and divider setup
// ----------------------------------------------------------------------------
module fpa_front
    import fpa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_fpa_in   i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_fpa_pipe o_data
);

    logic                     r_valid;
    t_fpa_pipe                r_data;
    t_fpa_pipe                n_data;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic [DATA_W-1:0]        mag_a;
    logic [DATA_W-1:0]        mag_b;
    logic [DATA_W:0]          sum;
    logic [DATA_W:0]          dif;
    logic [FRAC_BITS:0]       hi_a;

    assign a     = i_data.operand_a;
    assign b     = i_data.operand_b;
    assign mag_a = a[DATA_W-1] ? DATA_W'(0) - DATA_W'(a) : DATA_W'(a);
    assign mag_b = b[DATA_W-1] ? DATA_W'(0) - DATA_W'(b) : DATA_W'(b);
    assign sum   = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    assign dif   = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    assign hi_a  = a[DATA_W-1 -: FRAC_BITS+1];

    always_comb begin
        n_data        = '0;
        n_data.sel    = SEL_SIMPLE;
        n_data.neg    = a[DATA_W-1] ^ b[DATA_W-1];
        n_data.prod   = mag_a * mag_b;
        n_data.dvs    = mag_b;
        n_data.rem    = '0;
        n_data.quo    = QUO_W'({mag_a, {FRAC_BITS{1'b0}}});
        case (t_kind'(i_data.kind))
            K_ADD: begin
                if (sum[DATA_W] != sum[DATA_W-1]) begin
                    n_data.simple.overflow_flag = 1'b1;
                    n_data.simple.result_value  = sum[DATA_W] ? MIN_VAL : MAX_VAL;
                end else begin
                    n_data.simple.result_value = sum[DATA_W-1:0];
                end
            end
            K_SUB: begin
                if (dif[DATA_W] != dif[DATA_W-1]) begin
                    n_data.simple.overflow_flag = 1'b1;
                    n_data.simple.result_value  = dif[DATA_W] ? MIN_VAL : MAX_VAL;
                end else begin
                    n_data.simple.result_value = dif[DATA_W-1:0];
                end
            end
            K_MUL: n_data.sel = SEL_MUL;
            K_DIV: begin
                if (b == '0) begin
                    n_data.simple.divide_error = 1'b1;
                end else begin
                    n_data.sel = SEL_DIV;
                end
            end
            K_CMP: begin
                n_data.simple.less_flag    = a < b;
                n_data.simple.equal_flag   = a == b;
                n_data.simple.greater_flag = a > b;
            end
            K_MIN: n_data.simple.result_value = (a > b) ? b : a;
            K_MAX: n_data.simple.result_value = (a > b) ? a : b;
            K_INC: begin
                if (a == MAX_VAL) begin
                    n_data.simple.overflow_flag = 1'b1;
                    n_data.simple.result_value  = MAX_VAL;
                end else begin
                    n_data.simple.result_value = a + DATA_W'(1);
                end
            end
            K_DEC: begin
                if (a == MIN_VAL) begin
                    n_data.simple.overflow_flag = 1'b1;
                    n_data.simple.result_value  = MIN_VAL;
                end else begin
                    n_data.simple.result_value = a - DATA_W'(1);
                end
            end
            K_TO_INT: n_data.simple.result_value = a >>> FRAC_BITS;
            K_FROM_INT: begin
                if (hi_a != '0 && hi_a != '1) begin
                    n_data.simple.overflow_flag = 1'b1;
                    n_data.simple.result_value  = a[DATA_W-1] ? MIN_VAL : MAX_VAL;
                end else begin
                    n_data.simple.result_value = a <<< FRAC_BITS;
                end
            end
            default: n_data.simple = '0;
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/core/fpa_div_stage.sv
// ----------------------------------------------------------------------------
// fpa_div_stage
// one registered stage of the restoring divider, four quotient bits per stage
// ----------------------------------------------------------------------------
module fpa_div_stage
    import fpa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_fpa_pipe i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_fpa_pipe o_data
);

    logic      r_valid;
    t_fpa_pipe r_data;
    t_fpa_pipe n_data;

    always_comb begin
        logic [DATA_W:0]  rem_t;
        logic [QUO_W-1:0] quo_t;
        rem_t  = i_data.rem;
        quo_t  = i_data.quo;
        n_data = i_data;
        for (int i = 0; i < RADIX_BITS; i++) begin
            // numerator bits leave the top while quotient bits enter the bottom
            rem_t = {rem_t[DATA_W-1:0], quo_t[QUO_W-1]};
            quo_t = {quo_t[QUO_W-2:0], 1'b0};
            if (rem_t >= {1'b0, i_data.dvs}) begin
                rem_t    = rem_t - {1'b0, i_data.dvs};
                quo_t[0] = 1'b1;
            end
        end
        n_data.rem = rem_t;
        n_data.quo = quo_t;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/core/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// rounding, sign and saturation of multiply and divide, output register
// ----------------------------------------------------------------------------
module fpa_back
    import fpa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_fpa_pipe i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_fpa_out  o_data
);

    localparam logic [PROD_W-1:0] NEG_LIM = PROD_W'(1) << (DATA_W - 1);
    localparam logic [PROD_W-1:0] POS_LIM = NEG_LIM - PROD_W'(1);

    logic              r_valid;
    t_fpa_out          r_data;
    t_fpa_out          n_data;
    logic [PROD_W-1:0] mul_q;
    logic [QUO_W-1:0]  div_q;
    logic [PROD_W-1:0] mag;
    logic              rnd_up;

    // half away from zero on magnitudes
    assign mul_q  = (i_data.prod + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign rnd_up = {i_data.rem[DATA_W-1:0], 1'b0} >= {1'b0, i_data.dvs};
    assign div_q  = i_data.quo + QUO_W'(rnd_up);
    assign mag    = (i_data.sel == SEL_MUL) ? mul_q : PROD_W'(div_q);

    always_comb begin
        n_data = i_data.simple;
        if (i_data.sel == SEL_MUL || i_data.sel == SEL_DIV) begin
            if (i_data.neg) begin
                if (mag > NEG_LIM) begin
                    n_data.overflow_flag = 1'b1;
                    n_data.result_value  = MIN_VAL;
                end else begin
                    n_data.result_value = DATA_W'(0) - mag[DATA_W-1:0];
                end
            end else begin
                if (mag > POS_LIM) begin
                    n_data.overflow_flag = 1'b1;
                    n_data.result_value  = MAX_VAL;
                end else begin
                    n_data.result_value = mag[DATA_W-1:0];
                end
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/core/fixed_point_alu_q8.sv
// each transaction passes the front, 10 divider stages and back registers in order
// throughput: one transaction per cycle while the output is not stalled, set by the pipelined restoring divider
// the divider retires 4 quotient bits per stage over a 40-bit numerator
// every stage holds its own valid bit, so a stall only backs up full stages
// reset clears all valid bits synchronously; payload registers are not reset
// ----------------------------------------------------------------------------
// fixed_point_alu_q8
// signed q24.8 fixed-point alu with saturation and a pipelined divider
// ----------------------------------------------------------------------------
module fixed_point_alu_q8
    import fpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_fpa_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_fpa_out o_out_data
);

    logic      s_valid [DIV_STAGES+1];
    logic      s_ready [DIV_STAGES+1];
    t_fpa_pipe s_data  [DIV_STAGES+1];

    fpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (s_valid[0]),
        .i_ready (s_ready[0]),
        .o_data  (s_data[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        fpa_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[g]),
            .o_ready (s_ready[g]),
            .i_data  (s_data[g]),
            .o_valid (s_valid[g+1]),
            .i_ready (s_ready[g+1]),
            .o_data  (s_data[g+1])
        );
    end

    fpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid[DIV_STAGES]),
        .o_ready (s_ready[DIV_STAGES]),
        .i_data  (s_data[DIV_STAGES]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

`ifndef SYNTH
    a_cmp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_out_data.less_flag, o_out_data.equal_flag,
                                  o_out_data.greater_flag}))
        else $error("more than one compare flag set");

    a_derr_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.divide_error) |->
            (o_out_data.result_value == '0 && !o_out_data.overflow_flag))
        else $error("divide by zero result not clean");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.less_flag || o_out_data.equal_flag ||
                         o_out_data.greater_flag)) |->
            (o_out_data.result_value == '0 && !o_out_data.overflow_flag))
        else $error("compare result carries a value");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.overflow_flag) |->
            (o_out_data.result_value == MAX_VAL || o_out_data.result_value == MIN_VAL))
        else $error("overflow without saturated value");
`endif

endmodule
